### design/quaternion_to_euler_angles_top_defines.svh
// assertion macros used by the checker
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define QTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qte assertion failed");

// next-cycle implication, disabled during reset
`define QTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qte assertion failed");

`endif

### design/qte_pkg.sv
// shared types, constants and the arctangent table of the euler angle block
package qte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int CNT_W        = 5;
  localparam int VEC_W        = 36;
  localparam int ANG_W        = 29;
  localparam int CDEG_W       = 17;
  localparam int ANG_FRAC     = 12;
  localparam int RAD_W        = 57;
  localparam int ROOT_W       = 29;
  localparam int REM_W        = 31;

  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [CDEG_W-1:0] cdeg_t;

  localparam ang_t ANG_180 = 29'sd73728000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // atan(2^-i) in 1/4096 cdeg
  function automatic ang_t atan_lut(input logic [CNT_W-1:0] idx);
    ang_t v;
    case (idx)
      5'd0:  v = 29'sd18432000;
      5'd1:  v = 29'sd10881045;
      5'd2:  v = 29'sd5749245;
      5'd3:  v = 29'sd2918407;
      5'd4:  v = 29'sd1464867;
      5'd5:  v = 29'sd733147;
      5'd6:  v = 29'sd366663;
      5'd7:  v = 29'sd183343;
      5'd8:  v = 29'sd91673;
      5'd9:  v = 29'sd45837;
      5'd10: v = 29'sd22918;
      5'd11: v = 29'sd11459;
      5'd12: v = 29'sd5730;
      5'd13: v = 29'sd2865;
      5'd14: v = 29'sd1432;
      5'd15: v = 29'sd716;
      5'd16: v = 29'sd358;
      5'd17: v = 29'sd179;
      5'd18: v = 29'sd90;
      5'd19: v = 29'sd45;
      5'd20: v = 29'sd22;
      5'd21: v = 29'sd11;
      5'd22: v = 29'sd6;
      5'd23: v = 29'sd3;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/qte_cordic.sv
// vectoring cordic, one rotation per cycle, angle rounded to cdeg
module qte_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  qte_pkg::vec_t     y_in,
  input  qte_pkg::vec_t     x_in,
  output qte_pkg::cdeg_t    angle,
  output qte_pkg::unit_stat_t stat
);
  import qte_pkg::*;

  vec_t x_r, y_r, x_nxt, y_nxt, dx, dy;
  ang_t z_r, z_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r, done_r;
  logic signed [ANG_W:0] z_rnd;

  always_comb begin
    dx = x_r >>> cnt_r;
    dy = y_r >>> cnt_r;
    if (y_r[VEC_W-1]) begin
      x_nxt = x_r - dy;
      y_nxt = y_r + dx;
      z_nxt = z_r - atan_lut(cnt_r);
    end else begin
      x_nxt = x_r + dy;
      y_nxt = y_r - dx;
      z_nxt = z_r + atan_lut(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // left half plane: pre-rotate by 180 degrees
      if (x_in[VEC_W-1]) begin
        x_r <= -x_in;
        y_r <= -y_in;
        z_r <= y_in[VEC_W-1] ? -ANG_180 : ANG_180;
      end else begin
        x_r <= x_in;
        y_r <= y_in;
        z_r <= '0;
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign z_rnd = (ANG_W+1)'(z_r) + (ANG_W+1)'(1 << (ANG_FRAC - 1));
  assign angle = CDEG_W'(z_rnd >>> ANG_FRAC);
  assign stat  = '{busy: busy_r, done: done_r};

endmodule

### design/qte_isqrt.sv
// integer floor square root, two radicand bits per cycle
module qte_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [qte_pkg::RAD_W-1:0] n_in,
  output logic [qte_pkg::ROOT_W-1:0] root,
  output qte_pkg::unit_stat_t       stat
);
  import qte_pkg::*;

  logic [2*ROOT_W-1:0] sh_r;
  logic [REM_W-1:0]    rem_r, rem_sh, trial;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic busy_r, done_r;

  assign rem_sh = {rem_r[REM_W-3:0], sh_r[2*ROOT_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r   <= (2*ROOT_W)'(n_in);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      sh_r <= {sh_r[2*ROOT_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign stat = '{busy: busy_r, done: done_r};

endmodule

### design/quaternion_to_euler_angles_top.sv
// quaternion to roll, pitch and yaw in cdeg on one shared cordic
//
// input channel: in_quat_w/x/y/z, signed q14 (16384 = 1.0), valid/stall.
// output channel: out_roll_cdeg, out_pitch_cdeg, out_yaw_cdeg (yaw offset
// by 180 degrees), valid/stall. one result per input transfer.
// a single 16x16 multiplier builds the ten products in turn, then one
// vectoring cordic (16 rotations each) runs roll, pitch and yaw in turn;
// the pitch root overlaps roll. when a yaw operand is zero the yaw run is
// skipped and yaw repeats its last value; a zero roll operand repeats the
// last roll but saves no time, since the root still runs.
// in_stall is high from the input transfer until the result is loaded into
// the output register, so one item is at work at a time and a new input is
// taken only once the last result is loaded; a result waiting under
// out_stall does not block the next input, but the following result waits
// until the output register is free.
// reset (rst_n low, synchronous) empties the block and sets the held roll
// and yaw to zero.
module quaternion_to_euler_angles_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_roll_cdeg,
  output logic signed [14:0] out_pitch_cdeg,
  output logic        [15:0] out_yaw_cdeg
);
  import qte_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_CLAMP    = 4'd2;
  localparam logic [3:0] S_SQUARE   = 4'd3;
  localparam logic [3:0] S_ROLL_GO  = 4'd4;
  localparam logic [3:0] S_ROLL_W   = 4'd5;
  localparam logic [3:0] S_SQRT_W   = 4'd6;
  localparam logic [3:0] S_PITCH_GO = 4'd7;
  localparam logic [3:0] S_PITCH_W  = 4'd8;
  localparam logic [3:0] S_YAW_GO   = 4'd9;
  localparam logic [3:0] S_YAW_W    = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  localparam logic [3:0] MUL_LAST = 4'd9;
  localparam logic signed [32:0] HALF_Q28 = 33'sd134217728;
  localparam logic signed [33:0] ONE_Q28  = 34'sd268435456;

  logic [3:0] state_r, state_nxt;
  logic [3:0] mcnt_r;

  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] prod;
  logic signed [32:0] prod_x;
  logic signed [32:0] r_ay_r, r_ax_r, arg_r, y_ay_r, y_ax_r;
  logic signed [33:0] arg2;
  logic signed [29:0] argc_r;
  logic        [28:0] argmag;
  logic        [57:0] sq;
  logic [RAD_W-1:0]   n_r;

  logic signed [15:0] held_roll_r;
  logic        [15:0] held_yaw_r;
  logic signed [14:0] pitch_r;
  logic               out_valid_r;
  logic signed [15:0] out_roll_r;
  logic signed [14:0] out_pitch_r;
  logic        [15:0] out_yaw_r;

  logic roll_ok, yaw_ok, in_xfer, out_load;
  logic cor_start, sq_start;
  vec_t cor_y, cor_x;
  cdeg_t cor_angle;
  logic signed [CDEG_W:0] yaw_sum;
  logic [ROOT_W-1:0] root;
  unit_stat_t cor_stat, sq_stat;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign roll_ok  = (r_ay_r != '0) && (r_ax_r != '0);
  assign yaw_ok   = (y_ay_r != '0) && (y_ax_r != '0);

  // shared product schedule
  always_comb begin
    case (mcnt_r)
      4'd0:    begin mul_a = qw_r; mul_b = qx_r; end
      4'd1:    begin mul_a = qy_r; mul_b = qz_r; end
      4'd2:    begin mul_a = qx_r; mul_b = qx_r; end
      4'd3:    begin mul_a = qy_r; mul_b = qy_r; end
      4'd4:    begin mul_a = qw_r; mul_b = qy_r; end
      4'd5:    begin mul_a = qx_r; mul_b = qz_r; end
      4'd6:    begin mul_a = qx_r; mul_b = qy_r; end
      4'd7:    begin mul_a = qw_r; mul_b = qz_r; end
      4'd8:    begin mul_a = qy_r; mul_b = qy_r; end
      default: begin mul_a = qz_r; mul_b = qz_r; end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_x = 33'(prod);
  assign arg2   = {arg_r, 1'b0};
  assign argmag = argc_r[29] ? 29'(-argc_r) : 29'(argc_r);
  assign sq     = argmag * argmag;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_MUL;
      S_MUL:      if (mcnt_r == MUL_LAST) state_nxt = S_CLAMP;
      S_CLAMP:    state_nxt = S_SQUARE;
      S_SQUARE:   state_nxt = S_ROLL_GO;
      S_ROLL_GO:  state_nxt = roll_ok ? S_ROLL_W : S_SQRT_W;
      S_ROLL_W:   if (cor_stat.done) state_nxt = S_SQRT_W;
      S_SQRT_W:   if (!sq_stat.busy) state_nxt = S_PITCH_GO;
      S_PITCH_GO: state_nxt = S_PITCH_W;
      S_PITCH_W:  if (cor_stat.done) state_nxt = S_YAW_GO;
      S_YAW_GO:   state_nxt = yaw_ok ? S_YAW_W : S_OUT;
      S_YAW_W:    if (cor_stat.done) state_nxt = S_OUT;
      S_OUT:      if (out_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cor_start = 1'b0;
    cor_y = vec_t'(r_ay_r);
    cor_x = vec_t'(r_ax_r);
    unique case (state_r)
      S_ROLL_GO:  cor_start = roll_ok;
      S_PITCH_GO: begin
        cor_start = 1'b1;
        cor_y = vec_t'(argc_r);
        cor_x = vec_t'({1'b0, root});
      end
      S_YAW_GO: begin
        cor_start = yaw_ok;
        cor_y = vec_t'(y_ay_r);
        cor_x = vec_t'(y_ax_r);
      end
      default: cor_start = 1'b0;
    endcase
  end

  assign sq_start = (state_r == S_ROLL_GO);
  assign yaw_sum  = (CDEG_W+1)'(cor_angle) + (CDEG_W+1)'(18000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mcnt_r      <= '0;
      held_roll_r <= '0;
      held_yaw_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_MUL) mcnt_r <= mcnt_r + 1'b1;
      else mcnt_r <= '0;
      if (state_r == S_ROLL_W && cor_stat.done) begin
        if (cor_angle > 17'sd18000) held_roll_r <= 16'sd18000;
        else if (cor_angle < -17'sd18000) held_roll_r <= -16'sd18000;
        else held_roll_r <= 16'(cor_angle);
      end
      if (state_r == S_YAW_W && cor_stat.done) begin
        if (yaw_sum < 0) held_yaw_r <= '0;
        else if (yaw_sum > 18'sd36000) held_yaw_r <= 16'd36000;
        else held_yaw_r <= 16'(yaw_sum);
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      qw_r <= in_quat_w;
      qx_r <= in_quat_x;
      qy_r <= in_quat_y;
      qz_r <= in_quat_z;
    end
    if (state_r == S_MUL) begin
      case (mcnt_r)
        4'd0:    r_ay_r <= prod_x;
        4'd1:    r_ay_r <= r_ay_r + prod_x;
        4'd2:    r_ax_r <= HALF_Q28 - prod_x;
        4'd3:    r_ax_r <= r_ax_r - prod_x;
        4'd4:    arg_r  <= prod_x;
        4'd5:    arg_r  <= arg_r - prod_x;
        4'd6:    y_ay_r <= prod_x;
        4'd7:    y_ay_r <= y_ay_r + prod_x;
        4'd8:    y_ax_r <= HALF_Q28 - prod_x;
        default: y_ax_r <= y_ax_r - prod_x;
      endcase
    end
    if (state_r == S_CLAMP) begin
      if (arg2 > ONE_Q28) argc_r <= 30'(ONE_Q28);
      else if (arg2 < -ONE_Q28) argc_r <= 30'(-ONE_Q28);
      else argc_r <= 30'(arg2);
    end
    if (state_r == S_SQUARE) n_r <= RAD_W'(58'd1 << 56) - sq[RAD_W-1:0];
    if (state_r == S_PITCH_W && cor_stat.done) begin
      if (cor_angle > 17'sd9000) pitch_r <= 15'sd9000;
      else if (cor_angle < -17'sd9000) pitch_r <= -15'sd9000;
      else pitch_r <= 15'(cor_angle);
    end
    if (out_load) begin
      out_roll_r  <= held_roll_r;
      out_pitch_r <= pitch_r;
      out_yaw_r   <= held_yaw_r;
    end
  end

  qte_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .angle (cor_angle),
    .stat  (cor_stat)
  );

  qte_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .n_in  (n_r),
    .root  (root),
    .stat  (sq_stat)
  );

  assign out_valid      = out_valid_r;
  assign out_roll_cdeg  = out_roll_r;
  assign out_pitch_cdeg = out_pitch_r;
  assign out_yaw_cdeg   = out_yaw_r;

endmodule

### design/qte_checker.sv
// port-level checker for the euler angle block and its bind
`include "quaternion_to_euler_angles_top_defines.svh"

module qte_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [15:0] in_quat_w,
  input logic signed [15:0] in_quat_x,
  input logic signed [15:0] in_quat_y,
  input logic signed [15:0] in_quat_z,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_roll_cdeg,
  input logic signed [14:0] out_pitch_cdeg,
  input logic        [15:0] out_yaw_cdeg
);

  // a stalled result stays offered and unchanged
  `QTE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `QTE_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_roll_cdeg) && $stable(out_pitch_cdeg) && $stable(out_yaw_cdeg))
  // one item at a time: busy right after an input transfer
  `QTE_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)
  // saturated angle ranges
  `QTE_ASSERT_NOW(a_pitch_range, out_valid, out_pitch_cdeg <= 15'sd9000 && out_pitch_cdeg >= -15'sd9000)
  `QTE_ASSERT_NOW(a_angle_range, out_valid, out_yaw_cdeg <= 16'd36000 && out_roll_cdeg <= 16'sd18000 && out_roll_cdeg >= -16'sd18000)

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (.*);
